[hdl/cfs_pkg.sv]
// Types and codes shared by the circular FIFO with search.
// No dependencies; the core imports this package.
`default_nettype none
package cfs_pkg;

	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic               found;
		logic [1:0]         status;
	} rsp_t;

endpackage
`default_nettype wire

[hdl/circular_fifo_with_search_core.sv]
// Circular FIFO of words with push, pop and membership search requests.
// Depends on cfs_pkg for the request and response word types and codes.
// A push, an underflowing pop, an empty search or an unused code gives its result in the cycle
// after acceptance; a pop passes through S_POP_RD, and a search walks every entry in S_SRCH.
// Throughput: one request in flight; busy is high while a pop or search uses the read port.
// The search rate is set by the single read port of the entry memory, one entry per cycle.
// The receiver cannot stall: each result word is shown for one cycle with done high.
// Reset clears head, tail, count and control; memory contents are not cleared.
`default_nettype none
module circular_fifo_with_search_core #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire cfs_pkg::req_t req,
	output logic               done,
	output cfs_pkg::rsp_t      rsp
);
	import cfs_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_RD,
		S_SRCH
	} state_t;

	state_t                state_q;
	logic [IW-1:0]         head_q;
	logic [IW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         ptr_q;
	logic [CW-1:0]         left_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic                  hit_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	// Entry memory with a registered read port.
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [DATA_WIDTH-1:0] word;
	logic                  wr_en;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic                  hit_nx;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		logic [IW-1:0] r;
		if (i == IW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	// Pushed words and keys are held at the storage width: zero-extended or truncated.
	assign word = DATA_WIDTH'($unsigned(req.value));

	assign wr_en = accept && (req.req_type == REQ_PUSH) && !full;

	// The read port serves the head slot for a pop and the start of a search while
	// idle, then the walking pointer while a search is under way.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (state_q == S_SRCH) begin
			rd_en   = (left_q != '0);
			rd_addr = ptr_q;
		end else if (accept && !empty &&
				(req.req_type == REQ_POP || req.req_type == REQ_SEARCH)) begin
			rd_en = 1'b1;
		end
	end

	// The read data in the search state always belongs to the entry issued in the previous cycle.
	assign hit_nx = hit_q || (rdata_q == key_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= word;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Every path below gives done_q and rsp_q at most one assignment per edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			left_q  <= '0;
			key_q   <= '0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							REQ_PUSH: begin
								done_q <= 1'b1;
								if (full) begin
									rsp_q <= '{data_out: '0, found: 1'b0,
										status: ST_OVERFLOW};
								end else begin
									rsp_q   <= '{data_out: '0, found: 1'b0,
										status: ST_OK};
									tail_q  <= next_slot(tail_q);
									count_q <= count_q + 1'b1;
								end
							end
							REQ_POP: begin
								if (empty) begin
									done_q <= 1'b1;
									rsp_q  <= '{data_out: '0, found: 1'b0,
										status: ST_UNDERFLOW};
								end else begin
									done_q  <= 1'b0;
									head_q  <= next_slot(head_q);
									count_q <= count_q - 1'b1;
									state_q <= S_POP_RD;
								end
							end
							REQ_SEARCH: begin
								if (empty) begin
									done_q <= 1'b1;
									rsp_q  <= '{data_out: '0, found: 1'b0,
										status: ST_OK};
								end else begin
									done_q  <= 1'b0;
									key_q   <= word;
									ptr_q   <= next_slot(head_q);
									left_q  <= count_q - 1'b1;
									hit_q   <= 1'b0;
									state_q <= S_SRCH;
								end
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= '{data_out: '0, found: 1'b0, status: ST_OK};
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_POP_RD: begin
					done_q  <= 1'b1;
					rsp_q   <= '{data_out: 32'($signed(rdata_q)), found: 1'b0,
						status: ST_OK};
					state_q <= S_IDLE;
				end
				S_SRCH: begin
					if (left_q == '0) begin
						done_q  <= 1'b1;
						rsp_q   <= '{data_out: '0, found: hit_nx, status: ST_OK};
						state_q <= S_IDLE;
					end else begin
						done_q <= 1'b0;
						ptr_q  <= next_slot(ptr_q);
						left_q <= left_q - 1'b1;
						hit_q  <= hit_nx;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not advance the count");

	// A new request may be taken in the cycle the overflow result is shown, so the
	// queue is checked as it stood at the previous edge.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_OVERFLOW |-> $past(full))
		else $error("overflow reported with room left");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.found |-> rsp.status == ST_OK && rsp.data_out == '0)
		else $error("search hit with nonzero data or status");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("memory write while a read sequence is in flight");

endmodule
`default_nettype wire
